// ===== design/saf_pkg.sv =====
// Shared types, character codes and helper functions for the socket address
// text formatter. No dependencies; every other design file refers to this one.
package saf_pkg;

  typedef struct packed {
    logic        is_ip6;
    logic [63:0] ip6_high;
    logic [63:0] ip6_low;
    logic [31:0] ip4_address;
    logic [15:0] port_number;
    logic [31:0] scope_number;
  } item_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } result_t;

  typedef enum logic [1:0] {
    AM_GROUPS,
    AM_COMPAT,
    AM_MAPPED
  } addr_mode_e;

  typedef struct packed {
    item_t      item;
    logic [2:0] run_start;
    logic [3:0] run_length;
    addr_mode_e mode;
  } job_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_OPEN,
    ST_PRE_HEX,
    ST_PRE_SEP,
    ST_RUN_SEP,
    ST_POST_SEP,
    ST_POST_HEX,
    ST_TAIL_SEP,
    ST_PFX,
    ST_Q_DIG,
    ST_Q_DOT,
    ST_PCT,
    ST_CLOSE,
    ST_PCOL,
    ST_CONV,
    ST_FIND,
    ST_DIG,
    ST_DONE
  } st_e;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QIDX_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LBR   = 8'h5b;
  localparam logic [7:0] CH_RBR   = 8'h5d;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // "::ffff:"; the compatible form uses only its first two characters
  localparam logic [0:6][7:0] PFX_TEXT = {8'h3a, 8'h3a, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3a};
  localparam logic [2:0] PFX_LAST_COMPAT = 3'd1;
  localparam logic [2:0] PFX_LAST_MAPPED = 3'd6;

  localparam logic [15:0] GROUP_ONES = 16'hffff;
  localparam logic [3:0]  RUN_COMPAT = 4'd6;
  localparam logic [3:0]  RUN_MAPPED = 4'd5;
  localparam logic [3:0]  NUM_GROUPS = 4'd8;

  localparam logic [5:0] SCOPE_BITS = 6'd32;
  localparam logic [5:0] PORT_BITS  = 6'd16;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = CH_ZERO + {4'b0, n};
    end else begin
      c = 8'h57 + {4'b0, n};
    end
    return c;
  endfunction

  // index of the most significant nonzero nibble, 0 for a zero group
  function automatic logic [1:0] hex_top(input logic [15:0] g);
    logic [1:0] t;
    if (g[15:12] != 4'd0) begin
      t = 2'd3;
    end else if (g[11:8] != 4'd0) begin
      t = 2'd2;
    end else if (g[7:4] != 4'd0) begin
      t = 2'd1;
    end else begin
      t = 2'd0;
    end
    return t;
  endfunction

  function automatic logic [1:0] byte_top(input logic [7:0] b);
    logic [1:0] t;
    if (b >= 8'd100) begin
      t = 2'd2;
    end else if (b >= 8'd10) begin
      t = 2'd1;
    end else begin
      t = 2'd0;
    end
    return t;
  endfunction

  function automatic logic [11:0] byte_bcd(input logic [7:0] b);
    logic [19:0] s;
    s = {12'b0, b};
    for (int i = 0; i < 8; i++) begin
      for (int n = 0; n < 3; n++) begin
        if (s[8 + 4*n +: 4] >= 4'd5) begin
          s[8 + 4*n +: 4] = s[8 + 4*n +: 4] + 4'd3;
        end
      end
      s = {s[18:0], 1'b0};
    end
    return s[19:8];
  endfunction

  // one double-dabble step over ten BCD digits
  function automatic logic [39:0] dabble(input logic [39:0] b, input logic bin);
    logic [39:0] s;
    s = b;
    for (int n = 0; n < 10; n++) begin
      if (s[4*n +: 4] >= 4'd5) begin
        s[4*n +: 4] = s[4*n +: 4] + 4'd3;
      end
    end
    return {s[38:0], bin};
  endfunction

  function automatic logic [3:0] dec_top(input logic [39:0] b);
    logic [3:0] t;
    t = 4'd0;
    for (int n = 1; n < 10; n++) begin
      if (b[4*n +: 4] != 4'd0) begin
        t = 4'(n);
      end
    end
    return t;
  endfunction

  function automatic logic [15:0] group_of(input logic [63:0] hi, input logic [63:0] lo,
                                           input logic [2:0] idx);
    logic [15:0] g;
    case (idx)
      3'd0:    g = hi[63:48];
      3'd1:    g = hi[47:32];
      3'd2:    g = hi[31:16];
      3'd3:    g = hi[15:0];
      3'd4:    g = lo[63:48];
      3'd5:    g = lo[47:32];
      3'd6:    g = lo[31:16];
      default: g = lo[15:0];
    endcase
    return g;
  endfunction

  function automatic logic [7:0] byte_at(input logic [31:0] v, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = v[31:24];
      2'd1:    b = v[23:16];
      2'd2:    b = v[15:8];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

endpackage

// ===== design/saf_front.sv =====
// Front end: takes address requests, finds the IPv6 zero run and text form,
// and holds classified jobs in a two-entry queue. Uses saf_pkg.
module saf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  saf_pkg::item_t item_i,
  output logic           job_avail_o,
  input  logic           job_pop_i,
  output saf_pkg::job_t  job_o
);

  saf_pkg::job_t              mem_q [saf_pkg::QDEPTH];
  logic [saf_pkg::QIDX_W-1:0] wr_q, rd_q;
  logic [saf_pkg::QCNT_W-1:0] cnt_q;
  saf_pkg::job_t              job_new;
  logic                       take, give;

  // first longest run of two or more zero groups
  always_comb begin
    logic [3:0]  cur_start, cur_len, best_start, best_len;
    logic [15:0] g;
    cur_start  = 4'd0;
    cur_len    = 4'd0;
    best_start = 4'd0;
    best_len   = 4'd0;
    for (int i = 0; i < 8; i++) begin
      g = saf_pkg::group_of(item_i.ip6_high, item_i.ip6_low, 3'(i));
      if (g == 16'd0) begin
        if (cur_len == 4'd0) begin
          cur_start = 4'(i);
        end
        cur_len = cur_len + 4'd1;
      end else begin
        if (cur_len >= 4'd2 && cur_len > best_len) begin
          best_start = cur_start;
          best_len   = cur_len;
        end
        cur_len = 4'd0;
      end
    end
    if (cur_len >= 4'd2 && cur_len > best_len) begin
      best_start = cur_start;
      best_len   = cur_len;
    end
    job_new.item       = item_i;
    job_new.run_start  = best_start[2:0];
    job_new.run_length = best_len;
    job_new.mode       = saf_pkg::AM_GROUPS;
    if (best_len != 4'd0 && best_start == 4'd0) begin
      if (best_len == saf_pkg::RUN_COMPAT && item_i.ip6_low[31:16] != 16'd0) begin
        job_new.mode = saf_pkg::AM_COMPAT;
      end else if (best_len == saf_pkg::RUN_MAPPED &&
                   item_i.ip6_low[47:32] == saf_pkg::GROUP_ONES) begin
        job_new.mode = saf_pkg::AM_MAPPED;
      end
    end
  end

  assign full_o      = (cnt_q == saf_pkg::QCNT_W'(saf_pkg::QDEPTH));
  assign job_avail_o = (cnt_q != '0);
  assign take        = push_i && !full_o;
  assign give        = job_pop_i && job_avail_o;
  assign job_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (take) begin
        wr_q <= wr_q + 1'b1;
      end
      if (give) begin
        rd_q <= rd_q + 1'b1;
      end
      if (take && !give) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (give && !take) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mem_q[wr_q] <= job_new;
    end
  end

endmodule

// ===== design/saf_back.sv =====
// Back end: walks one classified job and emits its text a character a cycle unless
// stalled or converting a number; a one-char holdback marks the last. Uses saf_pkg.
module saf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_avail_i,
  output logic             job_pop_o,
  input  saf_pkg::job_t    job_i,
  output logic             empty_o,
  input  logic             pop_i,
  output saf_pkg::result_t result_o
);

  saf_pkg::st_e     state_q, state_d;
  saf_pkg::job_t    job_q, job_d;
  logic [2:0]       gi_q, gi_d, pi_q, pi_d;
  logic [1:0]       nib_q, nib_d, bi_q, bi_d, qd_q, qd_d;
  logic [31:0]      dv_q, dv_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [39:0]      bcd_q, bcd_d;
  logic [3:0]       dig_q, dig_d;
  logic             dec_port_q, dec_port_d;
  logic [7:0]       pend_q;
  logic             pend_valid_q;
  saf_pkg::result_t out_q;
  logic             out_valid_q;

  logic             emit_en, can_put, step, push_out;
  logic [7:0]       emit_char;
  logic [15:0]      cur_grp;
  logic [31:0]      qv;
  logic [7:0]       cur_byte;
  logic [11:0]      cur_bcd3;

  function automatic saf_pkg::st_e addr_start(input saf_pkg::job_t j);
    saf_pkg::st_e s;
    if (j.mode != saf_pkg::AM_GROUPS) begin
      s = saf_pkg::ST_PFX;
    end else if (j.run_length == 4'd0) begin
      s = saf_pkg::ST_POST_HEX;
    end else if (j.run_start == 3'd0) begin
      s = saf_pkg::ST_RUN_SEP;
    end else begin
      s = saf_pkg::ST_PRE_HEX;
    end
    return s;
  endfunction

  function automatic saf_pkg::st_e after_addr(input saf_pkg::job_t j);
    saf_pkg::st_e s;
    if (j.item.scope_number != 32'd0) begin
      s = saf_pkg::ST_PCT;
    end else if (j.item.port_number != 16'd0) begin
      s = saf_pkg::ST_CLOSE;
    end else begin
      s = saf_pkg::ST_DONE;
    end
    return s;
  endfunction

  assign cur_grp  = saf_pkg::group_of(job_q.item.ip6_high, job_q.item.ip6_low, gi_q);
  assign qv       = job_q.item.is_ip6 ? job_q.item.ip6_low[31:0] : job_q.item.ip4_address;
  assign cur_byte = saf_pkg::byte_at(qv, bi_q);
  assign cur_bcd3 = saf_pkg::byte_bcd(cur_byte);

  // character output per state
  always_comb begin
    emit_en   = 1'b1;
    emit_char = saf_pkg::CH_COLON;
    case (state_q)
      saf_pkg::ST_OPEN:     emit_char = saf_pkg::CH_LBR;
      saf_pkg::ST_PRE_HEX,
      saf_pkg::ST_POST_HEX: emit_char = saf_pkg::hex_char(cur_grp[nib_q*4 +: 4]);
      saf_pkg::ST_PRE_SEP,
      saf_pkg::ST_RUN_SEP,
      saf_pkg::ST_POST_SEP,
      saf_pkg::ST_TAIL_SEP,
      saf_pkg::ST_PCOL:     emit_char = saf_pkg::CH_COLON;
      saf_pkg::ST_PFX:      emit_char = saf_pkg::PFX_TEXT[pi_q];
      saf_pkg::ST_Q_DIG:    emit_char = saf_pkg::CH_ZERO + {4'b0, cur_bcd3[qd_q*4 +: 4]};
      saf_pkg::ST_Q_DOT:    emit_char = saf_pkg::CH_DOT;
      saf_pkg::ST_PCT:      emit_char = saf_pkg::CH_PCT;
      saf_pkg::ST_CLOSE:    emit_char = saf_pkg::CH_RBR;
      saf_pkg::ST_DIG:      emit_char = saf_pkg::CH_ZERO + {4'b0, bcd_q[dig_q*4 +: 4]};
      default:              emit_en   = 1'b0;
    endcase
  end

  assign can_put  = !out_valid_q || pop_i;
  assign step     = (state_q == saf_pkg::ST_DONE) ? can_put
                                                  : !(emit_en && pend_valid_q && !can_put);
  assign push_out = step && ((emit_en && pend_valid_q) || state_q == saf_pkg::ST_DONE);

  // next state and walk counters
  always_comb begin
    logic       load_nib, load_qd, start_scope, start_port;
    logic [3:0] run_end;
    state_d     = state_q;
    job_d       = job_q;
    gi_d        = gi_q;
    pi_d        = pi_q;
    nib_d       = nib_q;
    bi_d        = bi_q;
    qd_d        = qd_q;
    dv_d        = dv_q;
    cnt_d       = cnt_q;
    bcd_d       = bcd_q;
    dig_d       = dig_q;
    dec_port_d  = dec_port_q;
    job_pop_o   = 1'b0;
    load_nib    = 1'b0;
    load_qd     = 1'b0;
    start_scope = 1'b0;
    start_port  = 1'b0;
    run_end     = {1'b0, job_q.run_start} + job_q.run_length;
    if (step) begin
      case (state_q)
        saf_pkg::ST_IDLE: begin
          if (job_avail_i) begin
            job_pop_o = 1'b1;
            job_d     = job_i;
            gi_d      = 3'd0;
            pi_d      = 3'd0;
            bi_d      = 2'd0;
            if (job_i.item.is_ip6) begin
              load_nib = 1'b1;
              state_d  = (job_i.item.port_number != 16'd0) ? saf_pkg::ST_OPEN
                                                           : addr_start(job_i);
            end else if (job_i.item.port_number == 16'd0 ||
                         job_i.item.ip4_address != 32'd0) begin
              load_qd = 1'b1;
              state_d = saf_pkg::ST_Q_DIG;
            end else begin
              start_port = 1'b1;
            end
          end
        end
        saf_pkg::ST_OPEN: begin
          state_d = addr_start(job_q);
        end
        saf_pkg::ST_PRE_HEX: begin
          if (nib_q == 2'd0) begin
            state_d = saf_pkg::ST_PRE_SEP;
          end else begin
            nib_d = nib_q - 2'd1;
          end
        end
        saf_pkg::ST_PRE_SEP: begin
          if (gi_q + 3'd1 == job_q.run_start) begin
            gi_d     = run_end[2:0];
            load_nib = 1'b1;
            state_d  = (run_end >= saf_pkg::NUM_GROUPS) ? saf_pkg::ST_TAIL_SEP
                                                        : saf_pkg::ST_POST_SEP;
          end else begin
            gi_d     = gi_q + 3'd1;
            load_nib = 1'b1;
            state_d  = saf_pkg::ST_PRE_HEX;
          end
        end
        saf_pkg::ST_RUN_SEP: begin
          gi_d     = run_end[2:0];
          load_nib = 1'b1;
          state_d  = (run_end >= saf_pkg::NUM_GROUPS) ? saf_pkg::ST_TAIL_SEP
                                                      : saf_pkg::ST_POST_SEP;
        end
        saf_pkg::ST_POST_SEP: begin
          state_d = saf_pkg::ST_POST_HEX;
        end
        saf_pkg::ST_POST_HEX: begin
          if (nib_q != 2'd0) begin
            nib_d = nib_q - 2'd1;
          end else if (gi_q == 3'd7) begin
            state_d = after_addr(job_q);
          end else begin
            gi_d     = gi_q + 3'd1;
            load_nib = 1'b1;
            state_d  = saf_pkg::ST_POST_SEP;
          end
        end
        saf_pkg::ST_TAIL_SEP: begin
          state_d = after_addr(job_q);
        end
        saf_pkg::ST_PFX: begin
          if (pi_q == ((job_q.mode == saf_pkg::AM_MAPPED) ? saf_pkg::PFX_LAST_MAPPED
                                                          : saf_pkg::PFX_LAST_COMPAT)) begin
            bi_d    = 2'd0;
            load_qd = 1'b1;
            state_d = saf_pkg::ST_Q_DIG;
          end else begin
            pi_d = pi_q + 3'd1;
          end
        end
        saf_pkg::ST_Q_DIG: begin
          if (qd_q != 2'd0) begin
            qd_d = qd_q - 2'd1;
          end else if (bi_q != 2'd3) begin
            state_d = saf_pkg::ST_Q_DOT;
          end else if (job_q.item.is_ip6) begin
            state_d = after_addr(job_q);
          end else begin
            state_d = (job_q.item.port_number != 16'd0) ? saf_pkg::ST_PCOL
                                                        : saf_pkg::ST_DONE;
          end
        end
        saf_pkg::ST_Q_DOT: begin
          bi_d    = bi_q + 2'd1;
          load_qd = 1'b1;
          state_d = saf_pkg::ST_Q_DIG;
        end
        saf_pkg::ST_PCT: begin
          start_scope = 1'b1;
        end
        saf_pkg::ST_CLOSE: begin
          state_d = saf_pkg::ST_PCOL;
        end
        saf_pkg::ST_PCOL: begin
          start_port = 1'b1;
        end
        saf_pkg::ST_CONV: begin
          bcd_d = saf_pkg::dabble(bcd_q, dv_q[31]);
          dv_d  = {dv_q[30:0], 1'b0};
          cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            state_d = saf_pkg::ST_FIND;
          end
        end
        saf_pkg::ST_FIND: begin
          dig_d   = saf_pkg::dec_top(bcd_q);
          state_d = saf_pkg::ST_DIG;
        end
        saf_pkg::ST_DIG: begin
          if (dig_q != 4'd0) begin
            dig_d = dig_q - 4'd1;
          end else if (!dec_port_q && job_q.item.port_number != 16'd0) begin
            state_d = saf_pkg::ST_CLOSE;
          end else begin
            state_d = saf_pkg::ST_DONE;
          end
        end
        saf_pkg::ST_DONE: begin
          state_d = saf_pkg::ST_IDLE;
        end
        default: begin
          state_d = saf_pkg::ST_IDLE;
        end
      endcase
    end
    if (load_nib) begin
      nib_d = saf_pkg::hex_top(saf_pkg::group_of(job_d.item.ip6_high,
                                                 job_d.item.ip6_low, gi_d));
    end
    if (load_qd) begin
      qd_d = saf_pkg::byte_top(saf_pkg::byte_at(
        job_d.item.is_ip6 ? job_d.item.ip6_low[31:0] : job_d.item.ip4_address, bi_d));
    end
    if (start_scope || start_port) begin
      // port is left-aligned so both conversions take the top bit first
      dv_d       = start_port ? {job_d.item.port_number, 16'd0} : job_d.item.scope_number;
      cnt_d      = start_port ? saf_pkg::PORT_BITS : saf_pkg::SCOPE_BITS;
      bcd_d      = '0;
      dec_port_d = start_port;
      state_d    = saf_pkg::ST_CONV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= saf_pkg::ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (step && emit_en) begin
        pend_valid_q <= 1'b1;
      end else if (step && state_q == saf_pkg::ST_DONE) begin
        pend_valid_q <= 1'b0;
      end
      if (push_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    gi_q       <= gi_d;
    pi_q       <= pi_d;
    nib_q      <= nib_d;
    bi_q       <= bi_d;
    qd_q       <= qd_d;
    dv_q       <= dv_d;
    cnt_q      <= cnt_d;
    bcd_q      <= bcd_d;
    dig_q      <= dig_d;
    dec_port_q <= dec_port_d;
    if (step && emit_en) begin
      pend_q <= emit_char;
    end
    if (push_out) begin
      out_q.text_char <= pend_q;
      out_q.last_char <= (state_q == saf_pkg::ST_DONE);
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

endmodule

// ===== design/socket_address_text_formatter.sv =====
// Socket address text formatter top level: front classifier and back emitter.
// Depends on saf_pkg, saf_front and saf_back.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+-------------------------------
//   request  | in        | push_i / full_o   | item_i   (saf_pkg::item_t)
//   result   | out       | pop_i / empty_o   | result_o (saf_pkg::result_t)
//
// One character leaves per cycle while the output is popped; each decimal
// number (scope, port) first runs through a bit-serial BCD converter, which
// emits no characters. Two requests queue between front and back, so a new
// one is taken while text is still going out. Reset clears queue, walker
// state and output register.
module socket_address_text_formatter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  saf_pkg::item_t   item_i,
  output logic             empty_o,
  input  logic             pop_i,
  output saf_pkg::result_t result_o
);

  logic          job_avail, job_pop;
  saf_pkg::job_t job;

  saf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .item_i      (item_i),
    .job_avail_o (job_avail),
    .job_pop_i   (job_pop),
    .job_o       (job)
  );

  saf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (job_avail),
    .job_pop_o   (job_pop),
    .job_i       (job),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .result_o    (result_o)
  );

`ifndef SYNTHESIS
  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_avail) else $error("job taken from empty queue");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !job_pop |=> full_o) else $error("queue drained without a take");

  a_full_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> job_avail) else $error("queue full yet no job offered");
`endif

endmodule
